// File: hdl/xed_pkg.sv
`timescale 1ns / 1ps
// Shared types, character codes and helper functions for the XML entity decoder.
package xed_pkg;

    typedef logic [7:0] octet_t;
    typedef octet_t [3:0] seq4_t;

    localparam octet_t CH_AMP  = 8'h26;  // '&'
    localparam octet_t CH_SEMI = 8'h3B;  // ';'
    localparam octet_t CH_HASH = 8'h23;  // '#'
    localparam octet_t CH_X    = 8'h78;  // 'x'
    localparam octet_t CH_LT   = 8'h3C;  // '<'
    localparam octet_t CH_GT   = 8'h3E;  // '>'
    localparam octet_t CH_APOS = 8'h27;  // '''
    localparam octet_t CH_QUOT = 8'h22;  // '"'
    localparam octet_t CH_LA   = 8'h61;  // 'a'
    localparam octet_t CH_LF   = 8'h66;  // 'f'
    localparam octet_t CH_G    = 8'h67;
    localparam octet_t CH_L    = 8'h6C;
    localparam octet_t CH_M    = 8'h6D;
    localparam octet_t CH_O    = 8'h6F;
    localparam octet_t CH_P    = 8'h70;
    localparam octet_t CH_Q    = 8'h71;
    localparam octet_t CH_S    = 8'h73;
    localparam octet_t CH_T    = 8'h74;
    localparam octet_t CH_U    = 8'h75;
    localparam octet_t CH_UA   = 8'h41;  // 'A'
    localparam octet_t CH_UF   = 8'h46;  // 'F'
    localparam octet_t CH_D0   = 8'h30;  // '0'
    localparam octet_t CH_D9   = 8'h39;  // '9'

    localparam int         CP_W     = 21;
    localparam int         ACC_W    = 25;
    localparam logic [20:0] CODE_MAX = 21'h10FFFF;

    // controller -> datapath
    typedef struct packed {
        logic capture;
        logic eval;
        logic finish;
        logic load_amp;
        logic load_name;
        logic load_tail;
    } xed_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic flush;
        logic fin;
        logic name_empty;
        logic name_last;
        logic tail_empty;
        logic tail_last;
        logic can_load;
    } xed_stat_t;

    function automatic logic is_dec(input octet_t c);
        return (c >= CH_D0) && (c <= CH_D9);
    endfunction

    function automatic logic is_hex(input octet_t c);
        return is_dec(c) || ((c >= CH_LA) && (c <= CH_LF)) || ((c >= CH_UA) && (c <= CH_UF));
    endfunction

    // 'a'..'f' and 'A'..'F' both have 1..6 in the low nibble
    function automatic logic [3:0] hex_digit(input octet_t c);
        return is_dec(c) ? c[3:0] : 4'(c[3:0] + 4'd9);
    endfunction

endpackage

// File: hdl/xed_if.sv
`timescale 1ns / 1ps
// Valid/ready stream interfaces for text beats in and decoded beats out.
interface xed_text_if;
    logic         valid;
    logic         ready;
    logic [7:0]   text_byte;
    logic         end_of_text;

    modport source (output valid, output text_byte, output end_of_text, input ready);
    modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface xed_result_if;
    logic         valid;
    logic         ready;
    logic [7:0]   out_byte;
    logic         last_of_run;
    logic         text_done;

    modport source (output valid, output out_byte, output last_of_run, output text_done,
                    input ready);
    modport sink   (input valid, input out_byte, input last_of_run, input text_done,
                    output ready);
endinterface

// File: hdl/xed_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module xed_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

// File: hdl/xed_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for the entity decoder: accept, evaluate, then emit the run beat by beat.
module xed_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              ready,
    input  xed_pkg::xed_stat_t stat,
    output xed_pkg::xed_cmd_t  cmd
);
    import xed_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_FINISH,
        ST_DISPATCH,
        ST_AMP,
        ST_NAME,
        ST_TAIL
    } state_t;

    state_t state_reg, state_next;
    logic   ready_reg, ready_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && ready_reg)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                cmd.eval   = 1'b1;
                state_next = ST_DISPATCH;
            end
            ST_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = ST_DISPATCH;
            end
            ST_DISPATCH:
            begin
                if (stat.flush)
                begin
                    state_next = ST_AMP;
                end
                else if (!stat.tail_empty)
                begin
                    state_next = ST_TAIL;
                end
                else if (stat.fin)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_AMP:
            begin
                if (stat.can_load)
                begin
                    cmd.load_amp = 1'b1;
                    if (!stat.name_empty)
                    begin
                        state_next = ST_NAME;
                    end
                    else if (!stat.tail_empty)
                    begin
                        state_next = ST_TAIL;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_NAME:
            begin
                if (stat.can_load)
                begin
                    cmd.load_name = 1'b1;
                    if (stat.name_last)
                    begin
                        state_next = stat.tail_empty ? ST_IDLE : ST_TAIL;
                    end
                end
            end
            ST_TAIL:
            begin
                if (stat.can_load)
                begin
                    cmd.load_tail = 1'b1;
                    if (stat.tail_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        ready_next = (state_next == ST_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= ready_next;
        end
    end

    assign ready = ready_reg;
endmodule

// File: hdl/xed_datapath.sv
`timescale 1ns / 1ps
// Entity state, name store, decode and UTF-8 encode, and the output beat register.
module xed_datapath #(
    parameter int NAME_CAPACITY = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  xed_pkg::octet_t    text_byte,
    input  logic               end_of_text,
    input  xed_pkg::xed_cmd_t  cmd,
    output xed_pkg::xed_stat_t stat,
    output logic               out_valid,
    output xed_pkg::octet_t    out_byte,
    output logic               last_of_run,
    output logic               text_done,
    input  logic               out_ready
);
    import xed_pkg::*;

    localparam int             CW  = $clog2(NAME_CAPACITY + 1);
    localparam int             AW  = $clog2(NAME_CAPACITY);
    localparam logic [CW-1:0]  CAP = CW'(NAME_CAPACITY);

    // captured input beat
    octet_t        byte_reg, byte_next;
    logic          eot_reg, eot_next;

    // open entity
    logic          in_entity_reg, in_entity_next;
    logic [CW-1:0] count_reg, count_next;
    seq4_t         head_reg, head_next;      // copy of the first four name bytes
    logic          all_dec_reg, all_dec_next;
    logic          all_hex_reg, all_hex_next;
    logic          too_big_reg, too_big_next;
    logic [20:0]   dec_reg, dec_next;
    logic [20:0]   hex_reg, hex_next;

    // plan of the current run
    logic          flush_reg, flush_next;
    logic [CW-1:0] flush_len_reg, flush_len_next;
    seq4_t         tail_reg, tail_next;
    logic [2:0]    tail_len_reg, tail_len_next;
    logic          fin_reg, fin_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [1:0]    tidx_reg, tidx_next;

    // output beat
    logic          out_valid_reg, out_valid_next;
    octet_t        out_byte_reg, out_byte_next;
    logic          last_reg, last_next;
    logic          done_reg, done_next;

    // name RAM
    logic          ram_we, ram_re;
    logic [AW-1:0] ram_raddr;
    octet_t        ram_rdata;

    logic          can_load, name_last, tail_last;
    logic [CW-1:0] idx_inc;

    // decode
    logic          kw_hit, dec_ok, hex_ok, code_ok;
    octet_t        kw_char;
    logic [20:0]   code_pt;
    seq4_t         enc;
    logic [2:0]    enc_len;

    // append
    logic          hexpath;
    logic [ACC_W-1:0] dec_wide, hex_wide;
    logic          do_open, do_close, do_append;

    assign can_load  = !out_valid_reg || out_ready;
    assign name_last = (idx_reg == CW'(flush_len_reg - 1'b1));
    assign tail_last = ({1'b0, tidx_reg} == 3'(tail_len_reg - 3'd1));
    assign idx_inc   = CW'(idx_reg + 1'b1);

    always_comb
    begin
        kw_hit  = 1'b1;
        kw_char = CH_LT;
        if (count_reg == CW'(2) && head_reg[0] == CH_L && head_reg[1] == CH_T)
        begin
            kw_char = CH_LT;
        end
        else if (count_reg == CW'(2) && head_reg[0] == CH_G && head_reg[1] == CH_T)
        begin
            kw_char = CH_GT;
        end
        else if (count_reg == CW'(3) && head_reg[0] == CH_LA && head_reg[1] == CH_M
                 && head_reg[2] == CH_P)
        begin
            kw_char = CH_AMP;
        end
        else if (count_reg == CW'(4) && head_reg[0] == CH_LA && head_reg[1] == CH_P
                 && head_reg[2] == CH_O && head_reg[3] == CH_S)
        begin
            kw_char = CH_APOS;
        end
        else if (count_reg == CW'(4) && head_reg[0] == CH_Q && head_reg[1] == CH_U
                 && head_reg[2] == CH_O && head_reg[3] == CH_T)
        begin
            kw_char = CH_QUOT;
        end
        else
        begin
            kw_hit = 1'b0;
        end

        dec_ok = (count_reg >= CW'(2)) && head_reg[0] == CH_HASH && is_dec(head_reg[1])
                 && all_dec_reg && !too_big_reg;
        hex_ok = (count_reg >= CW'(3)) && head_reg[0] == CH_HASH && head_reg[1] == CH_X
                 && all_hex_reg && !too_big_reg;
        code_ok = kw_hit || dec_ok || hex_ok;
        code_pt = kw_hit ? {13'b0, kw_char} : (dec_ok ? dec_reg : hex_reg);
    end

    // UTF-8 encode
    always_comb
    begin
        enc = '0;
        if (code_pt < 21'h80)
        begin
            enc[0]  = code_pt[7:0];
            enc_len = 3'd1;
        end
        else if (code_pt < 21'h800)
        begin
            enc[0]  = {3'b110, code_pt[10:6]};
            enc[1]  = {2'b10, code_pt[5:0]};
            enc_len = 3'd2;
        end
        else if (code_pt < 21'h10000)
        begin
            enc[0]  = {4'b1110, code_pt[15:12]};
            enc[1]  = {2'b10, code_pt[11:6]};
            enc[2]  = {2'b10, code_pt[5:0]};
            enc_len = 3'd3;
        end
        else
        begin
            enc[0]  = {5'b11110, code_pt[20:18]};
            enc[1]  = {2'b10, code_pt[17:12]};
            enc[2]  = {2'b10, code_pt[11:6]};
            enc[3]  = {2'b10, code_pt[5:0]};
            enc_len = 3'd4;
        end
    end

    assign hexpath  = (count_reg == CW'(1)) ? (byte_reg == CH_X) : (head_reg[1] == CH_X);
    assign dec_wide = ACC_W'({dec_reg, 3'b000}) + ACC_W'({dec_reg, 1'b0})
                      + ACC_W'(byte_reg[3:0]);
    assign hex_wide = ACC_W'({hex_reg, 4'b0000}) + ACC_W'(hex_digit(byte_reg));

    always_comb
    begin
        byte_next      = byte_reg;
        eot_next       = eot_reg;
        in_entity_next = in_entity_reg;
        count_next     = count_reg;
        head_next      = head_reg;
        all_dec_next   = all_dec_reg;
        all_hex_next   = all_hex_reg;
        too_big_next   = too_big_reg;
        dec_next       = dec_reg;
        hex_next       = hex_reg;
        flush_next     = flush_reg;
        flush_len_next = flush_len_reg;
        tail_next      = tail_reg;
        tail_len_next  = tail_len_reg;
        fin_next       = fin_reg;
        idx_next       = idx_reg;
        tidx_next      = tidx_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        last_next      = last_reg;
        done_next      = done_reg;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        ram_raddr      = '0;
        do_open        = 1'b0;
        do_close       = 1'b0;
        do_append      = 1'b0;

        if (cmd.capture)
        begin
            byte_next = text_byte;
            eot_next  = end_of_text;
        end

        if (cmd.eval)
        begin
            flush_next     = 1'b0;
            flush_len_next = count_reg;
            tail_next[0]   = byte_reg;
            tail_len_next  = 3'd0;
            fin_next       = 1'b0;
            tidx_next      = '0;
            if (!in_entity_reg)
            begin
                if (byte_reg == CH_AMP && !eot_reg)
                begin
                    do_open = 1'b1;
                end
                else
                begin
                    tail_len_next = 3'd1;
                end
            end
            else if (byte_reg == CH_SEMI)
            begin
                if (code_ok)
                begin
                    tail_next     = enc;
                    tail_len_next = enc_len;
                end
                else
                begin
                    flush_next    = 1'b1;       // '&', name, ';'
                    tail_len_next = 3'd1;
                end
                do_close = 1'b1;
            end
            else if (byte_reg == CH_AMP)
            begin
                flush_next = 1'b1;
                if (eot_reg)
                begin
                    tail_len_next = 3'd1;
                    do_close      = 1'b1;
                end
                else
                begin
                    do_open = 1'b1;
                end
            end
            else if (count_reg >= CAP)
            begin
                // name overflow: literal flush, then the byte itself
                flush_next    = 1'b1;
                tail_len_next = 3'd1;
                do_close      = 1'b1;
            end
            else
            begin
                do_append = 1'b1;
                fin_next  = eot_reg;
            end
            if (eot_reg && !do_append)
            begin
                do_close = 1'b1;
            end
        end

        if (cmd.finish)
        begin
            // entity cut by end of text, decoded as if ';' had followed
            fin_next       = 1'b0;
            flush_len_next = count_reg;
            tidx_next      = '0;
            if (code_ok)
            begin
                flush_next    = 1'b0;
                tail_next     = enc;
                tail_len_next = enc_len;
            end
            else
            begin
                flush_next    = 1'b1;
                tail_len_next = 3'd0;
            end
            do_close = 1'b1;
        end

        if (do_append)
        begin
            ram_we     = 1'b1;
            count_next = CW'(count_reg + 1'b1);
            if (count_reg < CW'(4))
            begin
                head_next[count_reg[1:0]] = byte_reg;
            end
            if (count_reg >= CW'(1))
            begin
                all_dec_next = all_dec_reg && is_dec(byte_reg);
            end
            if (count_reg >= CW'(2))
            begin
                all_hex_next = all_hex_reg && is_hex(byte_reg);
            end
            if (count_reg != '0 && !too_big_reg)
            begin
                if (!hexpath && is_dec(byte_reg))
                begin
                    if (dec_wide > ACC_W'(CODE_MAX))
                    begin
                        too_big_next = 1'b1;
                    end
                    else
                    begin
                        dec_next = dec_wide[20:0];
                    end
                end
                if (hexpath && count_reg >= CW'(2) && is_hex(byte_reg))
                begin
                    if (hex_wide > ACC_W'(CODE_MAX))
                    begin
                        too_big_next = 1'b1;
                    end
                    else
                    begin
                        hex_next = hex_wide[20:0];
                    end
                end
            end
        end

        if (do_open || do_close)
        begin
            in_entity_next = do_open;
            count_next     = '0;
            all_dec_next   = 1'b1;
            all_hex_next   = 1'b1;
            too_big_next   = 1'b0;
            dec_next       = '0;
            hex_next       = '0;
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cmd.load_amp)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = CH_AMP;
            last_next      = (flush_len_reg == '0) && (tail_len_reg == 3'd0);
            idx_next       = '0;
            ram_re         = 1'b1;
            ram_raddr      = '0;
        end
        else if (cmd.load_name)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = ram_rdata;
            last_next      = name_last && (tail_len_reg == 3'd0);
            idx_next       = idx_inc;
            ram_re         = 1'b1;
            ram_raddr      = idx_inc[AW-1:0];
        end
        else if (cmd.load_tail)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = tail_reg[tidx_reg];
            last_next      = tail_last;
            tidx_next      = 2'(tidx_reg + 1'b1);
        end
        done_next = (cmd.load_amp || cmd.load_name || cmd.load_tail)
                    ? (last_next && eot_reg) : done_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_entity_reg <= 1'b0;
            count_reg     <= '0;
            all_dec_reg   <= 1'b1;
            all_hex_reg   <= 1'b1;
            too_big_reg   <= 1'b0;
            dec_reg       <= '0;
            hex_reg       <= '0;
            flush_reg     <= 1'b0;
            flush_len_reg <= '0;
            tail_len_reg  <= '0;
            fin_reg       <= 1'b0;
            idx_reg       <= '0;
            tidx_reg      <= '0;
            out_valid_reg <= 1'b0;
            last_reg      <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            in_entity_reg <= in_entity_next;
            count_reg     <= count_next;
            all_dec_reg   <= all_dec_next;
            all_hex_reg   <= all_hex_next;
            too_big_reg   <= too_big_next;
            dec_reg       <= dec_next;
            hex_reg       <= hex_next;
            flush_reg     <= flush_next;
            flush_len_reg <= flush_len_next;
            tail_len_reg  <= tail_len_next;
            fin_reg       <= fin_next;
            idx_reg       <= idx_next;
            tidx_reg      <= tidx_next;
            out_valid_reg <= out_valid_next;
            last_reg      <= last_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg     <= byte_next;
        eot_reg      <= eot_next;
        head_reg     <= head_next;
        tail_reg     <= tail_next;
        out_byte_reg <= out_byte_next;
    end

    xed_ram #(
        .WIDTH (8),
        .DEPTH (NAME_CAPACITY)
    ) u_name_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (byte_reg),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign stat.flush      = flush_reg;
    assign stat.fin        = fin_reg;
    assign stat.name_empty = (flush_len_reg == '0);
    assign stat.name_last  = name_last;
    assign stat.tail_empty = (tail_len_reg == 3'd0);
    assign stat.tail_last  = tail_last;
    assign stat.can_load   = can_load;

    assign out_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign last_of_run = last_reg;
    assign text_done   = done_reg;

`ifndef ASSERT_OFF
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP)
        else $error("name count beyond capacity");

    a_closed_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !in_entity_reg |-> count_reg == '0)
        else $error("name bytes held outside an entity");

    a_load_gated: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_amp || cmd.load_name || cmd.load_tail) |-> can_load)
        else $error("output beat overwritten while stalled");

    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && done_reg) |-> last_reg)
        else $error("text_done without last_of_run");

    a_tail_len: assert property (@(posedge clk) disable iff (!rst_n)
        tail_len_reg <= 3'd4)
        else $error("tail length out of range");
`endif
endmodule

// File: hdl/xml_entity_decoder.sv
`timescale 1ns / 1ps
// Top level of the streaming XML character entity decoder.
//
// Text beats arrive on the text channel, decoded beats leave on the decoded
// channel. Plain bytes pass through; '&' opens an entity whose name, of at
// most NAME_CAPACITY bytes, is held up to ';', another '&' or end of text.
// lt, gt, amp, apos, quot and numeric references ("#" decimal, "#x" hex in
// either case, at most 0x10FFFF) turn into one to four UTF-8 beats; anything
// else is replayed literally as '&', the name and the ';' when one closed it.
// One text beat is handled at a time: it is accepted, evaluated and dispatched,
// then each decoded beat it produces is loaded, with a second pass (finish,
// dispatch) when the final byte of the text joins an open name, and any stall
// on the decoded side holds it. The rate is set by the single output beat
// register, which every decoded beat passes through, and by the name RAM,
// whose one read port replays a failed name one byte per cycle unless the
// decoded side stalls. last_of_run marks the final beat caused by one text
// beat and text_done the final beat of the text. Text beats that cause no
// output (name bytes) produce nothing on the decoded side.
module xml_entity_decoder #(
    parameter int NAME_CAPACITY = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    xed_text_if.sink      text,
    xed_result_if.source  decoded
);
    import xed_pkg::*;

    xed_cmd_t  cmd;    // sequencer commands
    xed_stat_t stat;   // datapath status back to the sequencer

    // sequencer: owns ready and steps through accept/evaluate/emit
    xed_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (text.valid),
        .ready    (text.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // datapath: entity state, name RAM, decode and the output beat register
    xed_datapath #(
        .NAME_CAPACITY (NAME_CAPACITY)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .text_byte   (text.text_byte),
        .end_of_text (text.end_of_text),
        .cmd         (cmd),
        .stat        (stat),
        .out_valid   (decoded.valid),
        .out_byte    (decoded.out_byte),
        .last_of_run (decoded.last_of_run),
        .text_done   (decoded.text_done),
        .out_ready   (decoded.ready)
    );
endmodule
